@@ rtl/next_prime_search_unit_defines.svh @@
// Assertion macros for the next prime search unit.
// Expects signals clk and rst_n in the scope of each use.
`ifndef NEXT_PRIME_SEARCH_UNIT_DEFINES_SVH
`define NEXT_PRIME_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nps: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nps: next-cycle check failed");

`endif

@@ rtl/nps_pkg.sv @@
// Shared types and constants of the next prime search unit.
// No dependencies; used by controller, datapath and top level.
`default_nettype none

package nps_pkg;

    localparam int FIELD_W       = 16;
    localparam int FIRST_DIVISOR = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TEST,
        ST_DIV,
        ST_EVAL,
        ST_NEXT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_start;
        logic init_test;
        logic div_start;
        logic next_divisor;
        logic next_candidate;
        logic mark_ovf;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic range_ok;
        logic cand_lt2;
        logic sq_gt_cand;
        logic div_busy;
        logic div_done;
        logic rem_zero;
        logic cand_at_limit;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/nps_rem_unit.sv @@
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// No package dependencies; instantiated by nps_datapath.
`default_nettype none

module nps_rem_unit #(
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [DATA_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[DATA_W-1]};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // subtract when the shifted partial remainder covers the divisor
            if (shifted >= {1'b0, dsr_reg})
                rem_next = DATA_W'(shifted - {1'b0, dsr_reg});
            else
                rem_next = shifted[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/nps_datapath.sv @@
// Search datapath: candidate, trial divisor, running square, result register.
// Depends on nps_pkg and nps_rem_unit.
`default_nettype none

module nps_datapath #(
    parameter int WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire nps_pkg::cmd_t               cmd,
    input  wire logic [nps_pkg::FIELD_W-1:0] start_value,
    output nps_pkg::status_t                 status,
    output logic [nps_pkg::FIELD_W-1:0]      prime_found,
    output logic                             overflow
);

    localparam int CAND_W = (WIDTH < nps_pkg::FIELD_W) ? WIDTH : nps_pkg::FIELD_W;
    localparam int SQ_W   = CAND_W + 1;
    localparam logic [CAND_W-1:0] LIMIT = '1;

    logic [CAND_W-1:0]           cand_reg, cand_next;
    logic [CAND_W-1:0]           div_reg, div_next;
    logic [SQ_W-1:0]             sq_reg, sq_next;
    logic                        range_ok_reg, range_ok_next;
    logic                        ovf_pend_reg, ovf_pend_next;
    logic [nps_pkg::FIELD_W-1:0] prime_found_reg, prime_found_next;
    logic                        overflow_reg, overflow_next;
    logic                        div_busy;
    logic                        div_done;
    logic [CAND_W-1:0]           remainder;

    nps_rem_unit #(
        .DATA_W (CAND_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (cand_reg),
        .divisor   (div_reg),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (remainder)
    );

    always_comb
    begin
        cand_next        = cand_reg;
        div_next         = div_reg;
        sq_next          = sq_reg;
        range_ok_next    = range_ok_reg;
        ovf_pend_next    = ovf_pend_reg;
        prime_found_next = prime_found_reg;
        overflow_next    = overflow_reg;
        if (cmd.load_start)
        begin
            cand_next     = start_value[CAND_W-1:0];
            range_ok_next = (start_value <= nps_pkg::FIELD_W'(LIMIT));
            ovf_pend_next = 1'b0;
        end
        if (cmd.next_candidate)
            cand_next = cand_reg + CAND_W'(1);
        if (cmd.init_test)
        begin
            div_next = CAND_W'(nps_pkg::FIRST_DIVISOR);
            sq_next  = SQ_W'(nps_pkg::FIRST_DIVISOR * nps_pkg::FIRST_DIVISOR);
        end
        if (cmd.next_divisor)
        begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_next  = sq_reg + {div_reg, 1'b1};
            div_next = div_reg + CAND_W'(1);
        end
        if (cmd.mark_ovf)
            ovf_pend_next = 1'b1;
        if (cmd.load_result)
        begin
            prime_found_next = ovf_pend_reg ? '0 : nps_pkg::FIELD_W'(cand_reg);
            overflow_next    = ovf_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg     <= '0;
            div_reg      <= '0;
            sq_reg       <= '0;
            range_ok_reg <= 1'b0;
            ovf_pend_reg <= 1'b0;
        end
        else
        begin
            cand_reg     <= cand_next;
            div_reg      <= div_next;
            sq_reg       <= sq_next;
            range_ok_reg <= range_ok_next;
            ovf_pend_reg <= ovf_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_found_reg <= prime_found_next;
        overflow_reg    <= overflow_next;
    end

    always_comb
    begin
        status.range_ok      = range_ok_reg;
        status.cand_lt2      = (cand_reg < CAND_W'(nps_pkg::FIRST_DIVISOR));
        status.sq_gt_cand    = (sq_reg > {1'b0, cand_reg});
        status.div_busy      = div_busy;
        status.div_done      = div_done;
        status.rem_zero      = (remainder == '0);
        status.cand_at_limit = (cand_reg == LIMIT);
    end

    assign prime_found = prime_found_reg;
    assign overflow    = overflow_reg;

endmodule

`default_nettype wire

@@ rtl/nps_controller.sv @@
// Search sequencer: walks candidates and trial divisors, owns output valid.
// Depends on nps_pkg and next_prime_search_unit_defines.svh.
`default_nettype none
`include "next_prime_search_unit_defines.svh"

module nps_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire nps_pkg::status_t status,
    output nps_pkg::cmd_t         cmd
);

    nps_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nps_pkg::ST_IDLE:
                if (in_valid)
                    state_next = nps_pkg::ST_LOAD;
            nps_pkg::ST_LOAD:
                state_next = status.range_ok ? nps_pkg::ST_TEST : nps_pkg::ST_FINISH;
            nps_pkg::ST_TEST:
            begin
                priority if (status.cand_lt2)
                    state_next = nps_pkg::ST_NEXT;
                else if (status.sq_gt_cand)
                    state_next = nps_pkg::ST_FINISH;
                else
                    state_next = nps_pkg::ST_DIV;
            end
            nps_pkg::ST_DIV:
                if (status.div_done)
                    state_next = nps_pkg::ST_EVAL;
            nps_pkg::ST_EVAL:
                state_next = status.rem_zero ? nps_pkg::ST_NEXT : nps_pkg::ST_TEST;
            nps_pkg::ST_NEXT:
                state_next = status.cand_at_limit ? nps_pkg::ST_FINISH : nps_pkg::ST_TEST;
            nps_pkg::ST_FINISH:
                if (out_free)
                    state_next = nps_pkg::ST_IDLE;
            default:
                state_next = nps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            nps_pkg::ST_IDLE:
                cmd.load_start = in_valid;
            nps_pkg::ST_LOAD:
            begin
                cmd.init_test = status.range_ok;
                cmd.mark_ovf  = !status.range_ok;
            end
            nps_pkg::ST_TEST:
                cmd.div_start = !status.cand_lt2 && !status.sq_gt_cand;
            nps_pkg::ST_DIV:
                cmd = '0;
            nps_pkg::ST_EVAL:
                cmd.next_divisor = !status.rem_zero;
            nps_pkg::ST_NEXT:
            begin
                cmd.mark_ovf       = status.cand_at_limit;
                cmd.next_candidate = !status.cand_at_limit;
                cmd.init_test      = !status.cand_at_limit;
            end
            nps_pkg::ST_FINISH:
                cmd.load_result = out_free;
            default:
                cmd = '0;
        endcase
    end

    assign out_valid_next = cmd.load_result ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != nps_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    `NPS_ASSERT_NEXT(a_div_waits, (state_reg == nps_pkg::ST_DIV) && !status.div_done, state_reg == nps_pkg::ST_DIV)
    `NPS_ASSERT_SAME(a_result_slot_free, cmd.load_result, !out_valid_reg || !out_stall)
    `NPS_ASSERT_SAME(a_div_idle_outside, (state_reg == nps_pkg::ST_TEST) || (state_reg == nps_pkg::ST_IDLE), !status.div_busy)
    `NPS_ASSERT_NEXT(a_div_runs, cmd.div_start, status.div_busy && (state_reg == nps_pkg::ST_DIV))

endmodule

`default_nettype wire

@@ rtl/next_prime_search_unit.sv @@
// Top level of the next prime search unit: controller plus datapath.
// Depends on nps_pkg, nps_controller, nps_datapath (and nps_rem_unit).
//
// Usage:
//   Request channel: in_valid / in_stall with start_value. A request is taken
//   at a rising edge with in_valid high and in_stall low. in_stall is high
//   for the whole search, so one request is worked on at a time.
//   Response channel: out_valid / out_stall with prime_found and overflow.
//   The response sits in an output register; while the receiver stalls it
//   holds, and the next request is still taken and searched. A finished
//   search waits in its last state only if the previous response is unread.
//   Search steps: each trial divisor passes through test, CAND_W serial
//   remainder steps, done and evaluate, with CAND_W = min(WIDTH, 16);
//   each rejected candidate passes through ST_NEXT (0 and 1 go straight
//   from test to it), and a request also passes through idle, load and
//   finish. Cost is set by the one-bit-per-cycle remainder loop.
//   Overflow: a start above 2^CAND_W - 1, or no prime up to it, gives
//   overflow = 1 and prime_found = 0.
//   Reset (rst_n low, asynchronous) drops any search and any pending
//   response; the unit comes up idle and ready for a request.
`default_nettype none

module next_prime_search_unit #(
    parameter int WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [nps_pkg::FIELD_W-1:0] start_value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [nps_pkg::FIELD_W-1:0]      prime_found,
    output logic                             overflow
);

    // command and status between the sequencer and the datapath
    nps_pkg::cmd_t    cmd;
    nps_pkg::status_t status;

    nps_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nps_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .start_value (start_value),
        .status      (status),
        .prime_found (prime_found),
        .overflow    (overflow)
    );

endmodule

`default_nettype wire
